### rtl/u8cv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cv_pkg
// Types and constants shared by the UTF-8 canonical validator and its channels.
// ----------------------------------------------------------------------------
package u8cv_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [1:0]  t_count;
    typedef logic [20:0] t_scalar;

    // Lead byte ranges
    localparam t_byte LEAD2_LO = 8'hC2;
    localparam t_byte LEAD2_HI = 8'hDF;
    localparam t_byte LEAD3_LO = 8'hE0;
    localparam t_byte LEAD3_HI = 8'hEF;
    localparam t_byte LEAD4_LO = 8'hF0;
    localparam t_byte LEAD4_HI = 8'hF4;
    localparam t_byte NUL_BYTE = 8'h00;

    // Continuation bytes are 10xxxxxx
    localparam logic [1:0] CONT_TAG = 2'b10;

    // Length classes: number of continuation bytes in the sequence
    localparam t_count CLASS_NONE = 2'd0;
    localparam t_count CLASS_TWO  = 2'd1;
    localparam t_count CLASS_THREE = 2'd2;
    localparam t_count CLASS_FOUR = 2'd3;

    localparam t_scalar MIN_TWO    = 21'h00080;
    localparam t_scalar MIN_THREE  = 21'h00800;
    localparam t_scalar MIN_FOUR   = 21'h10000;
    localparam t_scalar SCALAR_MAX = 21'h10FFFF;
    localparam t_scalar SURR_LO    = 21'h0D800;
    localparam t_scalar SURR_HI    = 21'h0DFFF;

    function automatic t_scalar class_minimum(input t_count cls);
        t_scalar m;
        case (cls)
            CLASS_TWO:   m = MIN_TWO;
            CLASS_THREE: m = MIN_THREE;
            default:     m = MIN_FOUR;
        endcase
        return m;
    endfunction

endpackage

### rtl/u8cv_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cv channel interfaces
// Valid/ready channels for input bytes and for the string verdict.
// ----------------------------------------------------------------------------
interface u8cv_byte_if;
    import u8cv_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8cv_verdict_if;
    logic valid;
    logic ready;
    logic string_valid;

    modport source (output valid, output string_valid, input ready);
    modport sink   (input valid, input string_valid, output ready);
endinterface

### rtl/utf8_canonical_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_canonical_validator
// Streaming check of a byte string for shortest-form UTF-8 without NUL.
// ----------------------------------------------------------------------------
// Takes one byte per beat, every cycle unless a stalled verdict holds the
// input register, with last_byte marking the end of the string. Each byte
// lands in an input register; as it leaves that register the decode state
// (pending continuations, partial scalar, length class, sticky failure) is
// updated from it, and on the last byte a single verdict beat is loaded into
// the output register and the state returns to reset. Throughput is one byte
// per cycle while the input register is not held. A stalled verdict holds the
// input register only when another last byte is waiting behind it. An empty
// string produces no beats and no verdict.
// ----------------------------------------------------------------------------
module utf8_canonical_validator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    u8cv_byte_if.sink              i_byte_if,
    u8cv_verdict_if.source         o_verdict_if
);
    import u8cv_pkg::*;

    // input register
    logic    r_s1_valid;
    t_byte   r_s1_byte;
    logic    r_s1_last;

    // decode state
    t_count  r_pend, n_pend;
    t_count  r_cls, n_cls;
    t_scalar r_ps, n_ps;
    logic    r_fail, n_fail;

    // output register
    logic    r_o_valid;
    logic    r_o_ok;

    logic    s1_fire;
    logic    in_fire;
    t_scalar shifted;

    assign s1_fire = r_s1_valid && (!r_s1_last || !r_o_valid || o_verdict_if.ready);
    assign i_byte_if.ready = !r_s1_valid || s1_fire;
    assign in_fire = i_byte_if.valid && i_byte_if.ready;

    assign o_verdict_if.valid        = r_o_valid;
    assign o_verdict_if.string_valid = r_o_ok;

    assign shifted = {r_ps[14:0], r_s1_byte[5:0]};

    always_comb begin
        n_pend = r_pend;
        n_cls  = r_cls;
        n_ps   = r_ps;
        n_fail = r_fail;
        if (r_pend == 2'd0) begin
            if (!r_s1_byte[7]) begin
                if (r_s1_byte == NUL_BYTE) n_fail = 1'b1;
            end else if (r_s1_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
                n_pend = 2'd1;
                n_cls  = CLASS_TWO;
                n_ps   = {16'd0, r_s1_byte[4:0]};
            end else if (r_s1_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
                n_pend = 2'd2;
                n_cls  = CLASS_THREE;
                n_ps   = {17'd0, r_s1_byte[3:0]};
            end else if (r_s1_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
                n_pend = 2'd3;
                n_cls  = CLASS_FOUR;
                n_ps   = {18'd0, r_s1_byte[2:0]};
            end else begin
                n_fail = 1'b1;
            end
        end else if (r_s1_byte[7:6] != CONT_TAG) begin
            // bad continuation: drop the sequence, byte is not reread
            n_fail = 1'b1;
            n_pend = 2'd0;
            n_cls  = CLASS_NONE;
            n_ps   = '0;
        end else begin
            n_pend = r_pend - 2'd1;
            n_ps   = shifted;
            if (r_pend == 2'd1) begin
                if (shifted < class_minimum(r_cls) || shifted > SCALAR_MAX ||
                    (shifted >= SURR_LO && shifted <= SURR_HI))
                    n_fail = 1'b1;
                n_cls = CLASS_NONE;
                n_ps  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte <= i_byte_if.data_byte;
            r_s1_last <= i_byte_if.last_byte;
        end
        if (s1_fire && r_s1_last) begin
            r_o_ok <= !(n_fail || (n_pend != 2'd0));
        end
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_pend     <= 2'd0;
            r_cls      <= CLASS_NONE;
            r_ps       <= '0;
            r_fail     <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire && r_s1_last) begin
                r_o_valid <= 1'b1;
            end else if (o_verdict_if.ready) begin
                r_o_valid <= 1'b0;
            end

            if (s1_fire) begin
                if (r_s1_last) begin
                    r_pend <= 2'd0;
                    r_cls  <= CLASS_NONE;
                    r_ps   <= '0;
                    r_fail <= 1'b0;
                end else begin
                    r_pend <= n_pend;
                    r_cls  <= n_cls;
                    r_ps   <= n_ps;
                    r_fail <= n_fail;
                end
            end
        end
    end

    // pending continuations never exceed the length class of the sequence
    a_pend_le_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= r_cls)
        else $error("pending continuations exceed length class");

    // outside a sequence no scalar bits are held
    a_ps_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd0) |-> (r_ps == '0 && r_cls == CLASS_NONE))
        else $error("stale scalar outside a sequence");

    // the last byte leaves the decode state clean
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_last) |=> (r_pend == 2'd0 && !r_fail))
        else $error("state not cleared after last byte");

    // a verdict beat only follows a processed last byte
    a_verdict_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(s1_fire && r_s1_last))
        else $error("verdict without last byte");

endmodule
